// File: rtl/lci_pkg.sv
`default_nettype none
package lci_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // width of one partial-product operand in the multipliers
  localparam int MUL_CHUNK = 32;

  typedef enum logic [1:0] {
    CNT_NONE    = 2'd0,
    CNT_TANGENT = 2'd1,
    CNT_TWO     = 2'd2
  } count_t;

endpackage
`default_nettype wire

// File: rtl/lci_mul.sv
`default_nettype none
module lci_mul #(
  parameter int WA = 33,
  parameter int WB = 33,
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  input  logic [SW-1:0]           side_in,
  output logic                    out_valid,
  output logic signed [WA+WB-1:0] p,
  output logic [SW-1:0]           side_out
);
  import lci_pkg::*;

  localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NP = NA * NB;
  localparam int AX = NA * MUL_CHUNK;
  localparam int BX = NB * MUL_CHUNK;
  localparam int XW = AX + BX;

  logic              vld [NP+1];
  logic              neg [NP+1];
  logic [AX-1:0]     ma  [NP+1];
  logic [BX-1:0]     mb  [NP+1];
  logic [XW-1:0]     acc [NP+1];
  logic [SW-1:0]     sd  [NP+1];

  logic [WA-1:0] abs_a;
  logic [WB-1:0] abs_b;
  logic [XW-1:0] sgn_acc;

  assign abs_a = a[WA-1] ? WA'(unsigned'(-a)) : WA'(unsigned'(a));
  assign abs_b = b[WB-1] ? WB'(unsigned'(-b)) : WB'(unsigned'(b));

  // magnitudes in, sign out
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ma[0]  <= AX'(abs_a);
      mb[0]  <= BX'(abs_b);
      neg[0] <= a[WA-1] ^ b[WB-1];
      acc[0] <= '0;
      sd[0]  <= side_in;
    end
  end

  // one partial product per stage
  for (genvar k = 1; k <= NP; k++) begin : g_pp
    localparam int IA = (k - 1) / NB;
    localparam int IB = (k - 1) % NB;
    logic [2*MUL_CHUNK-1:0] pp;

    assign pp = ma[k-1][IA*MUL_CHUNK +: MUL_CHUNK] * mb[k-1][IB*MUL_CHUNK +: MUL_CHUNK];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ma[k]  <= ma[k-1];
        mb[k]  <= mb[k-1];
        neg[k] <= neg[k-1];
        acc[k] <= acc[k-1] + (XW'(pp) << ((IA + IB) * MUL_CHUNK));
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign sgn_acc = neg[NP] ? -acc[NP] : acc[NP];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[NP];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p        <= signed'(sgn_acc[WA+WB-1:0]);
      side_out <= sd[NP];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lci_sqrt.sv
`default_nettype none
module lci_sqrt #(
  parameter int DW = 136,
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [DW-1:0]            x,
  input  logic [SW-1:0]            side_in,
  output logic                     out_valid,
  output logic [(DW+1)/2-1:0]      root_out,
  output logic [SW-1:0]            side_out
);
  import lci_pkg::*;

  localparam int RW = (DW + 1) / 2;
  localparam int XW = 2 * RW;

  logic          vld  [RW+1];
  logic [XW-1:0] xs   [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [RW+1:0] rem  [RW+1];
  logic [SW-1:0] sd   [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xs[0]   <= XW'(x);
      root[0] <= '0;
      rem[0]  <= '0;
      sd[0]   <= side_in;
    end
  end

  // one root bit per stage, two radicand bits in
  for (genvar k = 1; k <= RW; k++) begin : g_bit
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          ge;

    assign cur   = {rem[k-1], xs[k-1][2*(RW-k) +: 2]};
    assign trial = (RW+4)'({root[k-1], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        xs[k]   <= xs[k-1];
        root[k] <= RW'({root[k-1], ge});
        rem[k]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        sd[k]   <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root_out  = root[RW];
  assign side_out  = sd[RW];

endmodule
`default_nettype wire

// File: rtl/lci_div.sv
`default_nettype none
module lci_div #(
  parameter int NW  = 88,
  parameter int DWD = 68,
  parameter int QW  = 52,
  parameter int SW  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic [DWD-1:0]       den,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [QW:0]   quot,
  output logic [SW-1:0]        side_out
);
  import lci_pkg::*;

  localparam int MW = NW + 1;

  logic                 ve;
  logic signed [NW-1:0] num_r;
  logic [DWD-1:0]       den_r;
  logic [SW-1:0]        sd_e;

  logic signed [MW-1:0] nx;
  logic signed [MW-1:0] dx;
  logic [MW-1:0]        mag_n;

  logic           vld [QW+1];
  logic [MW-1:0]  mag [QW+1];
  logic [DWD-1:0] dv  [QW+1];
  logic [DWD-1:0] rem [QW+1];
  logic [QW-1:0]  q   [QW+1];
  logic           neg [QW+1];
  logic [SW-1:0]  sd  [QW+1];

  // floor division: negative numerators go through the ceiling of the magnitude
  assign nx    = MW'(num_r);
  assign dx    = signed'(MW'(den_r));
  assign mag_n = unsigned'(nx[MW-1] ? (dx - nx - signed'(MW'(1))) : nx);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve     <= 1'b0;
      vld[0] <= 1'b0;
    end else if (ce) begin
      ve     <= in_valid;
      vld[0] <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_r  <= num;
      den_r  <= den;
      sd_e   <= side_in;
      mag[0] <= mag_n;
      dv[0]  <= den_r;
      rem[0] <= DWD'(mag_n >> QW);
      q[0]   <= '0;
      neg[0] <= num_r[NW-1];
      sd[0]  <= sd_e;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DWD:0] cur;
    logic         ge;

    assign cur = {rem[k-1], mag[k-1][QW-k]};
    assign ge  = cur >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        mag[k] <= mag[k-1];
        dv[k]  <= dv[k-1];
        rem[k] <= ge ? DWD'(cur - {1'b0, dv[k-1]}) : DWD'(cur);
        q[k]   <= QW'({q[k-1], ge});
        neg[k] <= neg[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quot     <= neg[QW] ? -signed'({1'b0, q[QW]}) : signed'({1'b0, q[QW]});
      side_out <= sd[QW];
    end
  end

endmodule
`default_nettype wire

// File: rtl/line_circle_intersection_unit.sv
`default_nettype none
// Line and circle intersection. Each transaction carries a line y = a*x + b and a circle
// (centre, radius) in signed fixed point with FRAC_BITS fraction bits; the result gives
// the number of intersection points (0, 1 tangent, 2), both points with the minus-root
// point first, and a flag when a coordinate was clamped to the word range. The
// discriminant is exact. One transaction is taken every clock while the skid stage is
// empty; the pipeline depth is set mostly by the square root pipeline (2*WORD_BITS+4
// stages, one root bit each) and the two dividers (2*WORD_BITS-FRAC_BITS+4 stages, one
// quotient bit each), plus the multipliers built from 32x32 partial products.
module line_circle_intersection_unit #(
  parameter int FRAC_BITS = lci_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = lci_pkg::WORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // slope, intercept, centre_x, centre_y, radius
  input  logic [((5*WORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // point_count, first_x, first_y, second_x, second_y, saturated
  output logic [((4*WORD_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  import lci_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int OW = ((4*W+3+7)/8)*8;
  localparam int PW = 2*W + 4;
  localparam int DQ = 2*PW;
  localparam int RW = (DQ + 1) / 2;
  localparam int NW = PW + F + 4;
  localparam int QW = 2*W - F + 4;
  localparam int XQ = QW + 1;
  localparam int LW = W + XQ;
  localparam int YW = LW + 1;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] x0;
    logic [W:0]   d;
  } side1_t;

  typedef struct packed {
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [PW-1:0] h;
    logic [PW-1:0] qa;
  } side2_t;

  typedef struct packed {
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [PW-1:0] h;
    logic [PW-1:0] qa;
    logic          neg;
    logic          zero;
  } side3_t;

  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         neg;
    logic         zero;
  } side4_t;

  typedef struct packed {
    logic [W-1:0]  b;
    logic [XQ-1:0] x1;
    logic [XQ-1:0] x2;
    logic          neg;
    logic          zero;
  } side5_t;

  logic ce;
  logic skid_valid;
  logic [OW-1:0] skid_data;

  assign ce            = !skid_valid;
  assign s_axis_tready = ce;

  // input register
  logic signed [W-1:0] in_a, in_b, in_x0, in_y0;
  logic [W-2:0]        in_r;

  assign in_a  = signed'(s_axis_tdata[0*W +: W]);
  assign in_b  = signed'(s_axis_tdata[1*W +: W]);
  assign in_x0 = signed'(s_axis_tdata[2*W +: W]);
  assign in_y0 = signed'(s_axis_tdata[3*W +: W]);
  assign in_r  = s_axis_tdata[4*W +: W-1];

  logic                v0;
  logic signed [W-1:0] a0, b0, x00;
  logic [W-2:0]        r0;
  logic signed [W:0]   d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a0  <= in_a;
      b0  <= in_b;
      x00 <= in_x0;
      r0  <= in_r;
      d0  <= (W+1)'(in_b) - (W+1)'(in_y0);
    end
  end

  // a*d, a*a, a*x0, r*r
  side1_t                 s1_in, s1;
  logic [$bits(side1_t)-1:0] s1_bits;
  logic                   v1m;
  logic signed [2*W+1:0]  p_ad, p_aa, p_ax, p_rr;
  logic signed [W:0]      a0x, r0x;

  assign a0x   = (W+1)'(a0);
  assign r0x   = signed'({2'b00, r0});
  assign s1_in = '{a: a0, b: b0, x0: x00, d: d0};
  assign s1    = side1_t'(s1_bits);

  lci_mul #(.WA(W+1), .WB(W+1), .SW($bits(side1_t))) u_mul_ad (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v0), .a(a0x), .b(d0),
    .side_in(s1_in), .out_valid(v1m), .p(p_ad), .side_out(s1_bits)
  );
  lci_mul #(.WA(W+1), .WB(W+1), .SW(1)) u_mul_aa (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v0), .a(a0x), .b(a0x),
    .side_in(1'b0), .out_valid(), .p(p_aa), .side_out()
  );
  lci_mul #(.WA(W+1), .WB(W+1), .SW(1)) u_mul_ax (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v0), .a(a0x), .b((W+1)'(x00)),
    .side_in(1'b0), .out_valid(), .p(p_ax), .side_out()
  );
  lci_mul #(.WA(W+1), .WB(W+1), .SW(1)) u_mul_rr (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v0), .a(r0x), .b(r0x),
    .side_in(1'b0), .out_valid(), .p(p_rr), .side_out()
  );

  // quadratic coefficients
  logic                 v1;
  logic signed [PW-1:0] h1, qa1, e1, rr1;
  logic [W-1:0]         a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= v1m;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h1  <= PW'(p_ad) - (PW'(signed'(s1.x0)) <<< F);
      qa1 <= PW'(p_aa) + (signed'(PW'(1)) <<< (2*F));
      e1  <= PW'(p_ax) + (PW'(signed'(s1.d)) <<< F);
      rr1 <= PW'(p_rr);
      a1  <= s1.a;
      b1  <= s1.b;
    end
  end

  // qa*r*r and e*e
  side2_t                    s2_in, s2;
  logic [$bits(side2_t)-1:0] s2_bits;
  logic                      v2m;
  logic signed [DQ-1:0]      p_q, p_e;

  assign s2_in = '{a: a1, b: b1, h: h1, qa: qa1};
  assign s2    = side2_t'(s2_bits);

  lci_mul #(.WA(PW), .WB(PW), .SW($bits(side2_t))) u_mul_q (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1), .a(qa1), .b(rr1),
    .side_in(s2_in), .out_valid(v2m), .p(p_q), .side_out(s2_bits)
  );
  lci_mul #(.WA(PW), .WB(PW), .SW(1)) u_mul_e (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v1), .a(e1), .b(e1),
    .side_in(1'b0), .out_valid(), .p(p_e), .side_out()
  );

  // discriminant
  logic                 v2;
  logic signed [DQ-1:0] disc2;
  side2_t               s2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v2m;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      disc2 <= p_q - p_e;
      s2r   <= s2;
    end
  end

  side3_t                    s3_in, s3;
  logic [$bits(side3_t)-1:0] s3_bits;
  logic [DQ-1:0]             rad;
  logic                      v3m;
  logic [RW-1:0]             root;

  assign rad   = disc2[DQ-1] ? '0 : unsigned'(disc2);
  assign s3_in = '{a: s2r.a, b: s2r.b, h: s2r.h, qa: s2r.qa,
                   neg: disc2[DQ-1], zero: (disc2 == '0)};
  assign s3    = side3_t'(s3_bits);

  lci_sqrt #(.DW(DQ), .SW($bits(side3_t))) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v2), .x(rad), .side_in(s3_in),
    .out_valid(v3m), .root_out(root), .side_out(s3_bits)
  );

  // -h -/+ root
  logic                 v3;
  logic signed [PW+1:0] hx, sx;
  logic signed [PW+1:0] n1, n2;
  logic signed [PW-1:0] qa3;
  side4_t               s4r3;

  assign hx = (PW+2)'(signed'(s3.h));
  assign sx = signed'((PW+2)'(root));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v3m;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n1   <= -hx - sx;
      n2   <= sx - hx;
      qa3  <= signed'(s3.qa);
      s4r3 <= '{a: s3.a, b: s3.b, neg: s3.neg, zero: s3.zero};
    end
  end

  // round-to-nearest numerators and denominator
  logic                 v4;
  logic signed [NW-1:0] num1, num2;
  logic [PW-1:0]        den4;
  side4_t               s4r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num1 <= (NW'(n1) <<< (F+1)) + NW'(qa3);
      num2 <= (NW'(n2) <<< (F+1)) + NW'(qa3);
      den4 <= {qa3[PW-2:0], 1'b0};
      s4r4 <= s4r3;
    end
  end

  side4_t                    s4;
  logic [$bits(side4_t)-1:0] s4_bits;
  logic                      v5m;
  logic signed [XQ-1:0]      x1, x2;

  assign s4 = side4_t'(s4_bits);

  lci_div #(.NW(NW), .DWD(PW), .QW(QW), .SW($bits(side4_t))) u_div_1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v4), .num(num1), .den(den4),
    .side_in(s4r4), .out_valid(v5m), .quot(x1), .side_out(s4_bits)
  );
  lci_div #(.NW(NW), .DWD(PW), .QW(QW), .SW(1)) u_div_2 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v4), .num(num2), .den(den4),
    .side_in(1'b0), .out_valid(), .quot(x2), .side_out()
  );

  // a*x for the line points
  side5_t                    s5_in, s5;
  logic [$bits(side5_t)-1:0] s5_bits;
  logic                      v6m;
  logic signed [LW-1:0]      p_y1, p_y2;

  assign s5_in = '{b: s4.b, x1: x1, x2: x2, neg: s4.neg, zero: s4.zero};
  assign s5    = side5_t'(s5_bits);

  lci_mul #(.WA(W), .WB(XQ), .SW($bits(side5_t))) u_mul_y1 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v5m), .a(signed'(s4.a)), .b(x1),
    .side_in(s5_in), .out_valid(v6m), .p(p_y1), .side_out(s5_bits)
  );
  lci_mul #(.WA(W), .WB(XQ), .SW(1)) u_mul_y2 (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(v5m), .a(signed'(s4.a)), .b(x2),
    .side_in(1'b0), .out_valid(), .p(p_y2), .side_out()
  );

  // rounding offset
  logic                 v6;
  logic signed [LW-1:0] t1, t2;
  side5_t               s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (ce) begin
      v6 <= v6m;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t1 <= p_y1 + signed'(LW'(1) << (F-1));
      t2 <= p_y2 + signed'(LW'(1) << (F-1));
      s6 <= s5;
    end
  end

  // line points
  logic                 v7;
  logic signed [YW-1:0] y1, y2, xw1, xw2;
  logic                 neg7, zero7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (ce) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      y1    <= YW'(t1 >>> F) + YW'(signed'(s6.b));
      y2    <= YW'(t2 >>> F) + YW'(signed'(s6.b));
      xw1   <= YW'(signed'(s6.x1));
      xw2   <= YW'(signed'(s6.x2));
      neg7  <= s6.neg;
      zero7 <= s6.zero;
    end
  end

  // clamp and pack
  function automatic logic [W:0] clamp_w(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    logic [W:0]           r;
    hi = signed'(YW'({1'b0, {(W-1){1'b1}}}));
    lo = -hi - signed'(YW'(1));
    if (v > hi) begin
      r = {1'b1, hi[W-1:0]};
    end else if (v < lo) begin
      r = {1'b1, lo[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic [W:0]    cx1, cy1, cx2, cy2;
  logic          sat;
  count_t        cnt;
  logic [OW-1:0] res;

  assign cx1 = clamp_w(xw1);
  assign cy1 = clamp_w(y1);
  assign cx2 = clamp_w(xw2);
  assign cy2 = clamp_w(y2);
  assign sat = cx1[W] | cy1[W] | cx2[W] | cy2[W];
  assign cnt = zero7 ? CNT_TANGENT : CNT_TWO;
  assign res = neg7 ? OW'(CNT_NONE) :
               OW'({sat, cy2[W-1:0], cx2[W-1:0], cy1[W-1:0], cx1[W-1:0], cnt});

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= ce && v7;
      end
    end else if (ce && v7) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
      end else begin
        m_axis_tdata <= res;
      end
    end else if (ce && v7) begin
      skid_data <= res;
    end
  end

endmodule
`default_nettype wire
